@@ rtl/core/integer_to_radix_text_unit_macros.svh @@
// Assertion macros shared by the radix text conversion RTL.
`ifndef INTEGER_TO_RADIX_TEXT_UNIT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_UNIT_MACROS_SVH

// Check cons in the same cycle as ant.
`define ITRT_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("itrt assertion failed");

// Check cons in the cycle after ant.
`define ITRT_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("itrt assertion failed");

`endif

@@ rtl/core/itrt_pkg.sv @@
// Package with widths, codes, types and helper functions of the radix text unit.
`timescale 1ns / 1ps

package itrt_pkg;

  localparam int ValueBits      = 64;
  localparam int MaxPad         = 64;
  localparam int RadixBits      = 6;
  localparam int PadBits        = 7;
  localparam int CfgIndexBits   = 3;
  localparam int CfgDataBits    = 7;
  localparam int DigitBits      = 6;
  localparam int DigitAddrBits  = 6;
  localparam int DigitSlots     = 1 << DigitAddrBits;
  localparam int DigitCountBits = DigitAddrBits + 1;
  localparam int ChunkBits      = 8;
  localparam int ChunkCntBits   = 3;
  localparam int WordBytes      = 8;
  localparam int WordBits       = 8 * WordBytes;
  localparam int ByteCountBits  = 4;

  localparam logic [RadixBits-1:0] RadixMin = 6'd2;
  localparam logic [RadixBits-1:0] RadixMax = 6'd36;

  localparam logic [CfgIndexBits-1:0] CfgRadix      = 3'd0;
  localparam logic [CfgIndexBits-1:0] CfgZeroPad    = 3'd1;
  localparam logic [CfgIndexBits-1:0] CfgSpacePad   = 3'd2;
  localparam logic [CfgIndexBits-1:0] CfgUpperCase  = 3'd3;
  localparam logic [CfgIndexBits-1:0] CfgAlwaysSign = 3'd4;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CharSpace  = 8'h20;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } byte_beat_t;

  function automatic logic [PadBits-1:0] clamp_pad(input logic [PadBits-1:0] w);
    logic [PadBits-1:0] lim;
    lim = PadBits'(MaxPad);
    return (w > lim) ? lim : w;
  endfunction

  function automatic logic [7:0] digit_char(input logic [DigitBits-1:0] d,
                                            input logic upper);
    logic [7:0] d8;
    d8 = 8'(d);
    if (d8 < 8'd10) begin
      return CharZero + d8;
    end
    return (upper ? CharUpperA : CharLowerA) + (d8 - 8'd10);
  endfunction

endpackage

@@ rtl/core/itrt_div.sv @@
// Shared divide unit: eight restoring long-division steps of a value chunk by the base.
`timescale 1ns / 1ps

module itrt_div (
  input  logic [itrt_pkg::DigitBits-1:0] rem_i,
  input  logic [itrt_pkg::ChunkBits-1:0] bits_i,
  input  logic [itrt_pkg::RadixBits-1:0] base_i,
  output logic [itrt_pkg::DigitBits-1:0] rem_o,
  output logic [itrt_pkg::ChunkBits-1:0] quo_o
);
  import itrt_pkg::*;

  always_comb begin
    logic [DigitBits:0] r;
    r = {1'b0, rem_i};
    quo_o = '0;
    for (int i = ChunkBits - 1; i >= 0; i--) begin
      r = {r[DigitBits-1:0], bits_i[i]};
      if (r >= {1'b0, base_i}) begin
        r = r - {1'b0, base_i};
        quo_o[i] = 1'b1;
      end
    end
    rem_o = r[DigitBits-1:0];
  end

endmodule

@@ rtl/core/itrt_pack.sv @@
// Byte packer: gathers characters into eight-byte words behind an output register.
`timescale 1ns / 1ps

module itrt_pack (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itrt_pkg::byte_beat_t              beat_i,
  output logic                              beat_ready_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [itrt_pkg::WordBits-1:0]     m_axis_tdata,
  output logic [itrt_pkg::ByteCountBits-1:0] m_axis_tuser,
  output logic                              m_axis_tlast
);
  import itrt_pkg::*;

  logic [WordBits-1:0]      acc_word_q, acc_word_d;
  logic [ByteCountBits-1:0] acc_cnt_q, acc_cnt_d;
  logic                     acc_done_q, acc_done_d;
  logic                     acc_last_q, acc_last_d;
  logic                     out_valid_q, out_valid_d;
  logic [WordBits-1:0]      out_word_q, out_word_d;
  logic [ByteCountBits-1:0] out_cnt_q, out_cnt_d;
  logic                     out_last_q, out_last_d;
  logic                     move;

  assign move         = acc_done_q && (!out_valid_q || m_axis_tready);
  assign beat_ready_o = !acc_done_q;

  always_comb begin
    acc_word_d  = acc_word_q;
    acc_cnt_d   = acc_cnt_q;
    acc_done_d  = acc_done_q;
    acc_last_d  = acc_last_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    if (move) begin
      out_valid_d = 1'b1;
      out_word_d  = acc_word_q;
      out_cnt_d   = acc_cnt_q;
      out_last_d  = acc_last_q;
      acc_word_d  = '0;
      acc_cnt_d   = '0;
      acc_done_d  = 1'b0;
      acc_last_d  = 1'b0;
    end else if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (beat_i.valid && beat_ready_o) begin
      acc_word_d[acc_cnt_q[ChunkCntBits-1:0]*8 +: 8] = beat_i.data;
      acc_cnt_d  = acc_cnt_q + 1'b1;
      acc_done_d = beat_i.last || (acc_cnt_q == ByteCountBits'(WordBytes - 1));
      acc_last_d = beat_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_word_q  <= '0;
      acc_cnt_q   <= '0;
      acc_done_q  <= 1'b0;
      acc_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_word_q  <= acc_word_d;
      acc_cnt_q   <= acc_cnt_d;
      acc_done_q  <= acc_done_d;
      acc_last_q  <= acc_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_cnt_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/core/integer_to_radix_text_unit.sv @@
// Top level of the integer to radix text converter: registers, sequencer and digit store.
`timescale 1ns / 1ps
// Converts one 64-bit integer per transaction into its ASCII text in a base of 2 to 36.
// Input channel s_axis: tdata carries the value, tuser selects signed (1) or unsigned (0).
// Output channel m_axis: tdata carries up to eight characters, first one in the lowest
// byte, tuser the byte count (1 to 8), tlast marks the final word of the value's text.
// The cfg channel writes radix, zero pad width, space pad width, case and sign mode;
// cfg_ready_o is always high, and writes belong between items.
// Digits are found by long division of the value by the base through the shared
// divide unit, one digit per pass over the value's eight chunks; a zero value gives
// the single digit 0. A prepare state then sets up the padding, and one character
// leaves per cycle while the packer takes it; each finished word passes the packer
// and then the output register.
// One item is in work at a time: s_axis_tready is high only while the unit is idle.
// A stalled receiver holds the output register; characters then back up in the packer
// and the sequencer waits, with nothing lost.
// Reset empties the output and packer, returns the sequencer to idle and loads the
// register defaults: radix 10, no padding, upper case, no plus sign.
// The digit store needs no clearing pass: only digits of the current item are read.

module integer_to_radix_text_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [itrt_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [itrt_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [itrt_pkg::ValueBits-1:0]      s_axis_tdata,   // [63:0] number
  input  logic                                s_axis_tuser,   // [0] kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [itrt_pkg::WordBits-1:0]       m_axis_tdata,   // [63:0] text_bytes
  output logic [itrt_pkg::ByteCountBits-1:0]  m_axis_tuser,   // [3:0] byte_count
  output logic                                m_axis_tlast    // last_word
);
  import itrt_pkg::*;

  `include "integer_to_radix_text_unit_macros.svh"

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPrep = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [RadixBits-1:0]      radix_q;
  logic [PadBits-1:0]        zero_pad_q;
  logic [PadBits-1:0]        space_pad_q;
  logic                      upper_q;
  logic                      always_sign_q;

  logic [1:0]                state_q, state_d;
  logic                      kind_q, kind_d;
  logic                      sign_q, sign_d;
  logic [7:0]                sign_char_q, sign_char_d;
  logic [ValueBits-1:0]      value_q, value_d;
  logic [RadixBits-1:0]      base_q, base_d;
  logic [DigitBits-1:0]      rem_q, rem_d;
  logic [ChunkCntBits-1:0]   chunk_q, chunk_d;
  logic [DigitCountBits-1:0] nd_q, nd_d;
  logic [DigitAddrBits-1:0]  ptr_q, ptr_d;
  logic [DigitCountBits-1:0] dig_left_q, dig_left_d;
  logic [PadBits-1:0]        space_q, space_d;
  logic [PadBits-1:0]        zero_q, zero_d;

  logic [DigitBits-1:0]      digit_mem [DigitSlots];
  logic [DigitBits-1:0]      rd_data_q;
  logic                      wr_en;

  logic [DigitBits-1:0]      div_rem_in, div_rem;
  logic [ChunkBits-1:0]      div_quo;

  byte_beat_t                beat;
  logic                      beat_ready;

  logic [PadBits-1:0]        zp_eff, sp_eff, body;
  logic                      neg_in;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= 6'd10;
      zero_pad_q    <= '0;
      space_pad_q   <= '0;
      upper_q       <= 1'b1;
      always_sign_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgRadix:      radix_q       <= cfg_data_i[RadixBits-1:0];
        CfgZeroPad:    zero_pad_q    <= cfg_data_i[PadBits-1:0];
        CfgSpacePad:   space_pad_q   <= cfg_data_i[PadBits-1:0];
        CfgUpperCase:  upper_q       <= cfg_data_i[0];
        CfgAlwaysSign: always_sign_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign div_rem_in = (chunk_q == '0) ? '0 : rem_q;

  itrt_div u_div (
    .rem_i  (div_rem_in),
    .bits_i (value_q[ValueBits-1 -: ChunkBits]),
    .base_i (base_q),
    .rem_o  (div_rem),
    .quo_o  (div_quo)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign neg_in        = s_axis_tuser && s_axis_tdata[ValueBits-1];
  assign zp_eff        = clamp_pad(zero_pad_q);
  assign sp_eff        = clamp_pad(space_pad_q);
  assign body          = (zp_eff > PadBits'(nd_q)) ? zp_eff : PadBits'(nd_q);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    sign_d      = sign_q;
    sign_char_d = sign_char_q;
    value_d     = value_q;
    base_d      = base_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    nd_d        = nd_q;
    ptr_d       = ptr_q;
    dig_left_d  = dig_left_q;
    space_d     = space_q;
    zero_d      = zero_q;
    wr_en       = 1'b0;
    beat        = '0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          kind_d      = s_axis_tuser;
          sign_d      = neg_in || (s_axis_tuser && always_sign_q);
          sign_char_d = neg_in ? CharMinus : CharPlus;
          value_d     = neg_in ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
          if (radix_q < RadixMin) begin
            base_d = RadixMin;
          end else if (radix_q > RadixMax) begin
            base_d = RadixMax;
          end else begin
            base_d = radix_q;
          end
          chunk_d = '0;
          nd_d    = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        value_d = {value_q[ValueBits-ChunkBits-1:0], div_quo};
        rem_d   = div_rem;
        chunk_d = chunk_q + 1'b1;
        if ((chunk_q == '0) && (value_q == '0)) begin
          state_d = StPrep;
          if (nd_q == '0) begin
            wr_en = 1'b1;
            nd_d  = DigitCountBits'(1);
          end
        end else if (chunk_q == '1) begin
          wr_en = 1'b1;
          nd_d  = nd_q + 1'b1;
        end
      end
      StPrep: begin
        space_d    = (!kind_q && (sp_eff > body)) ? (sp_eff - body) : '0;
        zero_d     = (zp_eff > PadBits'(nd_q)) ? (zp_eff - PadBits'(nd_q)) : '0;
        dig_left_d = nd_q;
        ptr_d      = DigitAddrBits'(nd_q - 1'b1);
        state_d    = StEmit;
      end
      StEmit: begin
        beat.valid = 1'b1;
        priority if (space_q != '0) begin
          beat.data = CharSpace;
          if (beat_ready) space_d = space_q - 1'b1;
        end else if (sign_q) begin
          beat.data = sign_char_q;
          if (beat_ready) sign_d = 1'b0;
        end else if (zero_q != '0) begin
          beat.data = CharZero;
          if (beat_ready) zero_d = zero_q - 1'b1;
        end else begin
          beat.data = digit_char(rd_data_q, upper_q);
          beat.last = (dig_left_q == DigitCountBits'(1));
          if (beat_ready) begin
            ptr_d      = ptr_q - 1'b1;
            dig_left_d = dig_left_q - 1'b1;
            if (beat.last) state_d = StIdle;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      chunk_q <= '0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
      nd_q    <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    sign_q      <= sign_d;
    sign_char_q <= sign_char_d;
    value_q     <= value_d;
    base_q      <= base_d;
    rem_q       <= rem_d;
    ptr_q       <= ptr_d;
    dig_left_q  <= dig_left_d;
    space_q     <= space_d;
    zero_q      <= zero_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_mem[nd_q[DigitAddrBits-1:0]] <= div_rem;
    end
    rd_data_q <= digit_mem[ptr_d];
  end

  itrt_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (beat),
    .beat_ready_o  (beat_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `ITRT_ASSERT_SAME(a_idle_no_beat, s_axis_tready, !beat.valid)
  `ITRT_ASSERT_SAME(a_nd_bound, 1'b1, nd_q <= DigitCountBits'(DigitSlots))
  `ITRT_ASSERT_SAME(a_last_at_first_digit, beat.valid && beat.last, ptr_q == '0)
  `ITRT_ASSERT_NEXT(a_accept_starts_div, s_axis_tvalid && s_axis_tready, state_q == StDiv)
  `ITRT_ASSERT_SAME(a_emit_has_digits, state_q == StEmit, dig_left_q != '0)

endmodule
